@@ sv/seat_presence_window_classifier_unit_assert.svh @@
// Assertion macros shared by the seat presence classifier modules.
`ifndef SEAT_PRESENCE_WINDOW_CLASSIFIER_UNIT_ASSERT_SVH
`define SEAT_PRESENCE_WINDOW_CLASSIFIER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SPWC_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Property checked in the cycle after the trigger.
`define SPWC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ sv/spwc_pkg.sv @@
// Types and constants of the seat presence window classifier.
package spwc_pkg;

    localparam int ADC_W       = 12;
    localparam int MV_W        = 17;
    localparam int SUM_W       = 20;
    localparam int CNT_W       = 4;
    localparam int MV_SCALE    = 89900;
    localparam int MV_SHIFT    = 12;
    localparam int MV_PROD_W   = ADC_W + MV_W;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [SUM_W-1:0] SUM_MAX       = '1;
    localparam logic [MV_W-1:0]  THR_RESET_MV  = 17'd3000;

    typedef enum logic [1:0] {
        MODE_OCC_LOW  = 2'd0,
        MODE_OCC_HIGH = 2'd1,
        MODE_ADAPTIVE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STAT_BETWEEN = 2'd0,
        STAT_AT_HIGH = 2'd1,
        STAT_AT_LOW  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_LOW_THR  = 2'd1,
        CFG_HIGH_THR = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        mode_t            mode;
        logic [MV_W-1:0]  low_thr;
        logic [MV_W-1:0]  high_thr;
    } cfg_t;

endpackage

@@ sv/seat_presence_window_classifier_unit.sv @@
// Seat presence window classifier: configuration registers and pipeline top level.
//
// Input channel s_axis carries one sensor tick per transaction, a 12-bit
// converter code. Ticks are scaled to millivolts and summed; once WINDOW
// ticks are gathered, the next tick closes the window (its code is dropped)
// and one result transaction goes out on m_axis: the truncated average,
// the occupied flag and the adaptive status.
// Throughput: one tick per cycle; the pipeline has four register stages
// (input, window sum, average, result), and a window of WINDOW + 1 ticks
// yields one result. After the closing tick is taken, its window passes the
// window sum, average and result registers in turn to reach m_axis.
// Ticks that only add to the sum never wait for the output side; a closing
// tick waits only when every stage behind the accumulator is full. When the
// receiver stalls, the result holds in the output register and s_axis_tready
// drops only once the pipeline has filled up behind it.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high,
// only while the block is idle. Reset clears the sum, count and held status,
// sets mode 0 and both thresholds to 3000 mV, and empties the pipeline.
module seat_presence_window_classifier_unit #(
    parameter int WINDOW = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [spwc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [11:0] adc_code
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] average_mv, [17] seat_occupied, [19:18] adaptive_status
    output logic [spwc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 cfg_we,
    input  logic [spwc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spwc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    spwc_pkg::cfg_t                  cfg_reg;
    logic                            win_valid;
    logic                            win_ready;
    logic [spwc_pkg::SUM_W-1:0]      win_sum;
    logic                            avg_valid;
    logic                            avg_ready;
    logic [spwc_pkg::MV_W-1:0]       avg_mv;
    logic [spwc_pkg::MV_W-1:0]       out_avg_mv;
    logic                            out_occupied;
    spwc_pkg::status_t               out_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= spwc_pkg::MODE_OCC_LOW;
            cfg_reg.low_thr  <= spwc_pkg::THR_RESET_MV;
            cfg_reg.high_thr <= spwc_pkg::THR_RESET_MV;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spwc_pkg::CFG_MODE:
                begin
                    cfg_reg.mode <= spwc_pkg::mode_t'(cfg_wdata[1:0]);
                end
                spwc_pkg::CFG_LOW_THR:
                begin
                    cfg_reg.low_thr <= cfg_wdata;
                end
                spwc_pkg::CFG_HIGH_THR:
                begin
                    cfg_reg.high_thr <= cfg_wdata;
                end
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    spwc_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_code   (s_axis_tdata[spwc_pkg::ADC_W-1:0]),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win_sum   (win_sum)
    );

    spwc_avg #(
        .WINDOW (WINDOW)
    ) u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win_sum   (win_sum),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg_mv    (avg_mv)
    );

    spwc_classify u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .avg_valid    (avg_valid),
        .avg_ready    (avg_ready),
        .avg_mv       (avg_mv),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_avg_mv   (out_avg_mv),
        .out_occupied (out_occupied),
        .out_status   (out_status)
    );

    assign m_axis_tdata = {4'b0000, out_status, out_occupied, out_avg_mv};

endmodule

@@ sv/spwc_accum.sv @@
// Input register, code-to-millivolt scaling and window accumulator.
module spwc_accum #(
    parameter int WINDOW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [spwc_pkg::ADC_W-1:0]    in_code,
    output logic                          win_valid,
    input  logic                          win_ready,
    output logic [spwc_pkg::SUM_W-1:0]    win_sum
);

    logic                          code_valid_reg;
    logic [spwc_pkg::ADC_W-1:0]    code_reg;
    logic [spwc_pkg::CNT_W-1:0]    count_reg;
    logic [spwc_pkg::CNT_W-1:0]    count_next;
    logic [spwc_pkg::SUM_W-1:0]    sum_reg;
    logic [spwc_pkg::SUM_W-1:0]    sum_next;
    logic                          win_valid_reg;
    logic [spwc_pkg::SUM_W-1:0]    win_sum_reg;
    logic [spwc_pkg::MV_PROD_W-1:0] mv_prod;
    logic [spwc_pkg::MV_W-1:0]     mv;
    logic [spwc_pkg::SUM_W:0]      sum_wide;
    logic                          in_window;
    logic                          out_slot;
    logic                          acc_ready;
    logic                          take;

    assign mv_prod   = spwc_pkg::MV_PROD_W'(code_reg)
                     * spwc_pkg::MV_PROD_W'(spwc_pkg::MV_SCALE);
    assign mv        = mv_prod[spwc_pkg::MV_PROD_W-1:spwc_pkg::MV_SHIFT];
    assign sum_wide  = {1'b0, sum_reg} + (spwc_pkg::SUM_W+1)'(mv);
    assign in_window = count_reg < spwc_pkg::CNT_W'(WINDOW);
    assign out_slot  = !win_valid_reg || win_ready;
    // A closing tick needs room downstream; a gathering tick does not.
    assign acc_ready = in_window || out_slot;
    assign take      = code_valid_reg && acc_ready;
    assign in_ready  = !code_valid_reg || acc_ready;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (take)
        begin
            if (in_window)
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_wide[spwc_pkg::SUM_W] ? spwc_pkg::SUM_MAX
                                                       : sum_wide[spwc_pkg::SUM_W-1:0];
            end
            else
            begin
                count_next = '0;
                sum_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid_reg <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            win_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                code_valid_reg <= in_valid;
            end
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (out_slot)
            begin
                win_valid_reg <= take && !in_window;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= in_code;
        end
        if (out_slot && take && !in_window)
        begin
            win_sum_reg <= sum_reg;
        end
    end

    assign win_valid = win_valid_reg;
    assign win_sum   = win_sum_reg;

`include "seat_presence_window_classifier_unit_assert.svh"

    `SPWC_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= spwc_pkg::CNT_W'(WINDOW), "count past window")
    `SPWC_ASSERT_NEXT(a_close_clears, take && !in_window, count_reg == '0 && sum_reg == '0 && win_valid_reg, "window close did not clear and emit")

endmodule

@@ sv/spwc_avg.sv @@
// Window average by multiplication with a fixed reciprocal.
module spwc_avg #(
    parameter int WINDOW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        win_valid,
    output logic                        win_ready,
    input  logic [spwc_pkg::SUM_W-1:0]  win_sum,
    output logic                        avg_valid,
    input  logic                        avg_ready,
    output logic [spwc_pkg::MV_W-1:0]   avg_mv
);

    // ceil(2^24 / WINDOW): exact floor quotient for every 20-bit sum
    // since 2^4 is at least WINDOW.
    localparam logic [spwc_pkg::RECIP_W-1:0] RECIP =
        spwc_pkg::RECIP_W'(((1 << spwc_pkg::RECIP_SHIFT) + WINDOW - 1) / WINDOW);
    localparam int PROD_W = spwc_pkg::SUM_W + spwc_pkg::RECIP_W;

    logic                        avg_valid_reg;
    logic [spwc_pkg::MV_W-1:0]   avg_reg;
    logic [PROD_W-1:0]           prod;

    assign prod      = PROD_W'(win_sum) * PROD_W'(RECIP);
    assign win_ready = !avg_valid_reg || avg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_valid_reg <= 1'b0;
        end
        else if (win_ready)
        begin
            avg_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_ready && win_valid)
        begin
            avg_reg <= prod[spwc_pkg::RECIP_SHIFT+spwc_pkg::MV_W-1:spwc_pkg::RECIP_SHIFT];
        end
    end

    assign avg_valid = avg_valid_reg;
    assign avg_mv    = avg_reg;

endmodule

@@ sv/spwc_classify.sv @@
// Threshold classification, held adaptive status and result register.
module spwc_classify (
    input  logic                        clk,
    input  logic                        rst_n,
    input  spwc_pkg::cfg_t              cfg,
    input  logic                        avg_valid,
    output logic                        avg_ready,
    input  logic [spwc_pkg::MV_W-1:0]   avg_mv,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [spwc_pkg::MV_W-1:0]   out_avg_mv,
    output logic                        out_occupied,
    output spwc_pkg::status_t           out_status
);

    logic                        out_valid_reg;
    logic [spwc_pkg::MV_W-1:0]   out_avg_reg;
    logic                        out_occ_reg;
    spwc_pkg::status_t           out_status_reg;
    spwc_pkg::status_t           held_reg;
    spwc_pkg::status_t           held_next;
    logic                        occ_next;
    logic                        load;

    assign avg_ready = !out_valid_reg || out_ready;
    assign load      = avg_valid && avg_ready;

    always_comb
    begin
        held_next = held_reg;
        case (cfg.mode)
            spwc_pkg::MODE_OCC_LOW:
            begin
                occ_next = avg_mv < cfg.low_thr;
            end
            spwc_pkg::MODE_OCC_HIGH:
            begin
                occ_next = avg_mv > cfg.high_thr;
            end
            default:
            begin
                // Adaptive, also for the unused mode code: high test first.
                occ_next = 1'b1;
                if (avg_mv >= cfg.high_thr)
                begin
                    held_next = spwc_pkg::STAT_AT_HIGH;
                end
                else if (avg_mv <= cfg.low_thr)
                begin
                    held_next = spwc_pkg::STAT_AT_LOW;
                end
                else
                begin
                    held_next = spwc_pkg::STAT_BETWEEN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= spwc_pkg::STAT_BETWEEN;
        end
        else
        begin
            if (avg_ready)
            begin
                out_valid_reg <= avg_valid;
            end
            if (load)
            begin
                held_reg <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_avg_reg    <= avg_mv;
            out_occ_reg    <= occ_next;
            out_status_reg <= held_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_avg_mv   = out_avg_reg;
    assign out_occupied = out_occ_reg;
    assign out_status   = out_status_reg;

`include "seat_presence_window_classifier_unit_assert.svh"

    `SPWC_ASSERT_NEXT(a_held_matches_out, load, out_status_reg == held_reg, "result status differs from held status")

endmodule
